/* rtl/two_class_stable_priority_queue_macros.svh */
// assertion macros for the two-class stable priority queue
// no dependencies; included by the top level
`ifndef TWO_CLASS_STABLE_PRIORITY_QUEUE_MACROS_SVH
`define TWO_CLASS_STABLE_PRIORITY_QUEUE_MACROS_SVH

// clocked check, disabled while reset is asserted
`define TCSPQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tcspq check failed");

// clocked check that also holds during reset
`define TCSPQ_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("tcspq check failed");

`endif

/* rtl/tcspq_pkg.sv */
// shared types and constants of the two-class stable priority queue
// no dependencies
package tcspq_pkg;

  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TAG_W       = 64;
  localparam int unsigned KEY_W       = 8;
  localparam logic [KEY_W-1:0] THRESHOLD_RESET = KEY_W'(534 - 474);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DRAIN  = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_EMITTED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_DRAIN = 1'b1
  } state_e;

  typedef struct packed {
    logic insert;
    logic empty_drain;
    logic drain_step;
  } cmd_t;

  typedef struct packed {
    logic             count_zero;
    logic             count_one;
    logic [CNT_W-1:0] count;
  } sts_t;

endpackage

/* rtl/two_class_stable_priority_queue.sv */
// top level of the two-class stable priority queue
// depends on tcspq_pkg, tcspq_ctrl, tcspq_dp and the assertion macro header
//
// An insert's result word appears on the result ports the cycle after start
// is taken, and a new word may be started in that same cycle. A drain of N
// stored entries holds busy while it runs and gives N result words, one per
// cycle, the first after the state register and the result register, the last
// marked by last_o; a drain of an empty queue gives one word, registered. The
// drain rate is set by the slot shift register, which moves one entry to the
// head each cycle. Results are shown for exactly one cycle and cannot be
// stalled. The threshold port is always ready.
`include "two_class_stable_priority_queue_macros.svh"

module two_class_stable_priority_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         req_type_i,
  input  logic [tcspq_pkg::TAG_W-1:0]  entry_tag_i,
  input  logic [tcspq_pkg::KEY_W-1:0]  entry_key_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tcspq_pkg::KEY_W-1:0]  cfg_data_i,
  output logic                         result_valid_o,
  output logic [1:0]                   status_o,
  output logic [tcspq_pkg::TAG_W-1:0]  out_tag_o,
  output logic [tcspq_pkg::KEY_W-1:0]  out_key_o,
  output logic                         last_o
);

  tcspq_pkg::cmd_t cmd;
  tcspq_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  tcspq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .busy_o     (busy_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcspq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .entry_tag_i    (entry_tag_i),
    .entry_key_i    (entry_key_i),
    .thr_we_i       (cfg_valid_i && cfg_ready_o),
    .thr_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .out_tag_o      (out_tag_o),
    .out_key_o      (out_key_o),
    .last_o         (last_o)
  );

  `TCSPQ_ASSERT(a_count_bound, clk_i, rst_ni, sts.count <= tcspq_pkg::CNT_W'(tcspq_pkg::QUEUE_DEPTH))
  `TCSPQ_ASSERT(a_drain_ends_last, clk_i, rst_ni, $fell(busy_o) |-> (result_valid_o && last_o))
  `TCSPQ_ASSERT(a_busy_only_emits, clk_i, rst_ni, (busy_o && result_valid_o) |-> (status_o == tcspq_pkg::ST_EMITTED))
  `TCSPQ_ASSERT_ALWAYS(a_one_cmd, clk_i, $onehot0({cmd.insert, cmd.empty_drain, cmd.drain_step}))

endmodule

/* rtl/tcspq_dp.sv */
// datapath: slot shift register, fill count, threshold and result register
// depends on tcspq_pkg
module tcspq_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tcspq_pkg::cmd_t                cmd_i,
  output tcspq_pkg::sts_t                sts_o,
  input  logic [tcspq_pkg::TAG_W-1:0]    entry_tag_i,
  input  logic [tcspq_pkg::KEY_W-1:0]    entry_key_i,
  input  logic                           thr_we_i,
  input  logic [tcspq_pkg::KEY_W-1:0]    thr_data_i,
  output logic                           result_valid_o,
  output logic [1:0]                     status_o,
  output logic [tcspq_pkg::TAG_W-1:0]    out_tag_o,
  output logic [tcspq_pkg::KEY_W-1:0]    out_key_o,
  output logic                           last_o
);

  localparam int unsigned D = tcspq_pkg::QUEUE_DEPTH;

  logic [tcspq_pkg::TAG_W-1:0] tag_q [D];
  logic [tcspq_pkg::TAG_W-1:0] tag_d [D];
  logic [tcspq_pkg::KEY_W-1:0] key_q [D];
  logic [tcspq_pkg::KEY_W-1:0] key_d [D];
  logic [tcspq_pkg::CNT_W-1:0] count_q, count_d;
  logic [tcspq_pkg::KEY_W-1:0] thr_q;

  logic                        valid_q, valid_d;
  tcspq_pkg::status_e          status_q, status_d;
  logic [tcspq_pkg::TAG_W-1:0] otag_q, otag_d;
  logic [tcspq_pkg::KEY_W-1:0] okey_q, okey_d;
  logic                        last_q, last_d;

  logic         full;
  logic         promote;
  logic         do_insert;
  logic [D-1:0] mark;
  logic [D-1:0] at_or_after;

  assign full      = (count_q == tcspq_pkg::CNT_W'(D));
  assign promote   = (entry_key_i >= thr_q);
  assign do_insert = cmd_i.insert && !full;

  // insert point: first smaller stored key (promoted only), else the tail
  always_comb begin
    for (int i = 0; i < D; i++) begin
      mark[i] = ((tcspq_pkg::CNT_W'(i) < count_q) && promote && (key_q[i] < entry_key_i))
                || (tcspq_pkg::CNT_W'(i) == count_q);
    end
    for (int i = 0; i < D; i++) begin
      at_or_after[i] = |(mark << (D - 1 - i));
    end
  end

  always_comb begin
    for (int i = 0; i < D; i++) begin
      tag_d[i] = tag_q[i];
      key_d[i] = key_q[i];
    end
    if (do_insert) begin
      for (int i = 0; i < D; i++) begin
        if (i > 0 && at_or_after[(i > 0) ? i - 1 : 0]) begin
          tag_d[i] = tag_q[(i > 0) ? i - 1 : 0];
          key_d[i] = key_q[(i > 0) ? i - 1 : 0];
        end else if (at_or_after[i]) begin
          tag_d[i] = entry_tag_i;
          key_d[i] = entry_key_i;
        end
      end
    end else if (cmd_i.drain_step) begin
      for (int i = 0; i < D - 1; i++) begin
        tag_d[i] = tag_q[i + 1];
        key_d[i] = key_q[i + 1];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_insert) begin
      count_d = count_q + tcspq_pkg::CNT_W'(1);
    end else if (cmd_i.drain_step) begin
      count_d = count_q - tcspq_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    valid_d  = 1'b0;
    status_d = tcspq_pkg::ST_INSERTED;
    otag_d   = '0;
    okey_d   = '0;
    last_d   = 1'b1;
    if (cmd_i.insert) begin
      valid_d  = 1'b1;
      status_d = full ? tcspq_pkg::ST_DROPPED : tcspq_pkg::ST_INSERTED;
    end else if (cmd_i.empty_drain) begin
      valid_d  = 1'b1;
      status_d = tcspq_pkg::ST_EMPTY;
    end else if (cmd_i.drain_step) begin
      valid_d  = 1'b1;
      status_d = tcspq_pkg::ST_EMITTED;
      otag_d   = tag_q[0];
      okey_d   = key_q[0];
      last_d   = (count_q == tcspq_pkg::CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < D; i++) begin
      tag_q[i] <= tag_d[i];
      key_q[i] <= key_d[i];
    end
    status_q <= status_d;
    otag_q   <= otag_d;
    okey_q   <= okey_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
      thr_q   <= tcspq_pkg::THRESHOLD_RESET;
    end else begin
      count_q <= count_d;
      valid_q <= valid_d;
      if (thr_we_i) begin
        thr_q <= thr_data_i;
      end
    end
  end

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.count_one  = (count_q == tcspq_pkg::CNT_W'(1));
  assign sts_o.count      = count_q;

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign out_tag_o      = otag_q;
  assign out_key_o      = okey_q;
  assign last_o         = last_q;

endmodule

/* rtl/tcspq_ctrl.sv */
// controller: accepts commands and sequences the drain
// depends on tcspq_pkg
module tcspq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            req_type_i,
  output logic            busy_o,
  input  tcspq_pkg::sts_t sts_i,
  output tcspq_pkg::cmd_t cmd_o
);

  tcspq_pkg::state_e state_q, state_d;
  logic              accept;

  assign accept = start_i && (state_q == tcspq_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcspq_pkg::S_IDLE: begin
        if (accept && req_type_i == tcspq_pkg::REQ_DRAIN && !sts_i.count_zero) begin
          state_d = tcspq_pkg::S_DRAIN;
        end
      end
      tcspq_pkg::S_DRAIN: begin
        if (sts_i.count_one) begin
          state_d = tcspq_pkg::S_IDLE;
        end
      end
      default: state_d = tcspq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy_o            = 1'b0;
    cmd_o.insert      = 1'b0;
    cmd_o.empty_drain = 1'b0;
    cmd_o.drain_step  = 1'b0;
    unique case (state_q)
      tcspq_pkg::S_IDLE: begin
        cmd_o.insert      = accept && req_type_i == tcspq_pkg::REQ_INSERT;
        cmd_o.empty_drain = accept && req_type_i == tcspq_pkg::REQ_DRAIN && sts_i.count_zero;
      end
      tcspq_pkg::S_DRAIN: begin
        busy_o           = 1'b1;
        cmd_o.drain_step = 1'b1;
      end
      default: busy_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcspq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
